// ----- src/pf2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// pf2rgb_pkg: shared definitions for the pixel format to RGB24 converter
// Format mode codes, field widths and the BT.709 integer coefficients.
// ----------------------------------------------------------------------------
package pf2rgb_pkg;

   localparam int WORD_W  = 64;
   localparam int COORD_W = 14;
   localparam int CHAN_W  = 8;
   localparam int MODE_W  = 4;

   typedef logic [MODE_W-1:0] mode_type;

   // format mode codes
   localparam mode_type MODE_RGBA16_BLEND = 4'd0;
   localparam mode_type MODE_RGB48        = 4'd1;
   localparam mode_type MODE_YUV16_PAIR   = 4'd2;
   localparam mode_type MODE_R210         = 4'd3;
   localparam mode_type MODE_DPX0         = 4'd4;
   localparam mode_type MODE_AB10         = 4'd5;
   localparam mode_type MODE_AR10         = 4'd6;
   localparam mode_type MODE_RGB24        = 4'd7;
   localparam mode_type MODE_BGRA8        = 4'd8;
   localparam mode_type MODE_YUV8_PAIR    = 4'd9;

   localparam mode_type MODE_RESET = MODE_RGB24;

   // BT.709 video-range coefficients (Q13 for 8-bit, Q21 overall for 16-bit)
   localparam logic signed [15:0] COEF_Y  = 16'sd9535;
   localparam logic signed [15:0] COEF_RV = 16'sd14688;
   localparam logic signed [15:0] COEF_GU = 16'sd1745;
   localparam logic signed [15:0] COEF_GV = 16'sd4383;
   localparam logic signed [15:0] COEF_BU = 16'sd17326;

   // sample offsets, 17-bit signed working width
   localparam logic signed [16:0] Y_OFS16 = 17'sd4096;   // 16 << 8
   localparam logic signed [16:0] C_OFS16 = 17'sd32768;
   localparam logic signed [16:0] Y_OFS8  = 17'sd16;
   localparam logic signed [16:0] C_OFS8  = 17'sd128;

   localparam int SHIFT16 = 21;
   localparam int SHIFT8  = 13;

   // checkerboard greys behind the alpha blend
   localparam logic [CHAN_W-1:0] GREY_DARK  = 8'h20;
   localparam logic [CHAN_W-1:0] GREY_LIGHT = 8'h40;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

   localparam int CHECKER_BIT = 6;

endpackage

// ----- src/pixel_format_to_rgb24.sv -----
// ----------------------------------------------------------------------------
// pixel_format_to_rgb24: source pixel word to 8-bit RGB converter
// Unpacks one source pixel word per request into red/green/blue bytes in the
// format chosen by csr_write_data (pixel mode, reset rgb24). Single-pixel
// modes give one result per request and sustain one request per clock while
// the result side does not stall; the two 4:2:2 YUV pair modes give two
// results (Y1 pixel first), taking the next request as the second one goes;
// the one shared YUV datapath produces one pixel per cycle when not stalled.
// A request passes the input register, then the result register, which
// decouples the sides: an empty input register takes a request while a result waits.
// Change the pixel mode only while no request is in flight.
// ----------------------------------------------------------------------------
module pixel_format_to_rgb24 (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [pf2rgb_pkg::MODE_W-1:0]  csr_write_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pf2rgb_pkg::WORD_W-1:0]  req_pixel_word,
   input  logic [pf2rgb_pkg::COORD_W-1:0] req_column,
   input  logic [pf2rgb_pkg::COORD_W-1:0] req_row,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pf2rgb_pkg::CHAN_W-1:0]  rsp_red,
   output logic [pf2rgb_pkg::CHAN_W-1:0]  rsp_green,
   output logic [pf2rgb_pkg::CHAN_W-1:0]  rsp_blue,
   output logic                           rsp_last_of_item
);
   import pf2rgb_pkg::*;

   // YUV sum, shift and clamp to 0..255
   function automatic logic [CHAN_W-1:0] clamp_shift(input logic signed [32:0] v,
                                                     input logic wide);
      logic [32:0] sh;
      logic [CHAN_W-1:0] res;
      sh = wide ? (33'(v) >> SHIFT16) : (33'(v) >> SHIFT8);
      if (v[32]) begin
         res = '0;
      end else if (sh > 33'(CHAN_MAX)) begin
         res = CHAN_MAX;
      end else begin
         res = sh[CHAN_W-1:0];
      end
      return res;
   endfunction

   // alpha blend of one channel over grey
   function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] c,
                                               input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] grey);
      logic [15:0] mix;
      mix = 16'(c) * 16'(a) + 16'(grey) * (16'(CHAN_MAX) - 16'(a));
      return mix[15:8];
   endfunction

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   mode_type                pixel_mode_ff;
   logic                    s1_valid_ff,  s1_valid_in;
   logic                    phase_ff,     phase_in;     // 1: second pixel of pair
   logic [WORD_W-1:0]       s1_word_ff;
   logic                    s1_grey_sel_ff;            // checkerboard select

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]       rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                    rsp_last_ff;

   // ------------------------------------------------------------------------
   // Handshake control
   // ------------------------------------------------------------------------
   logic out_free;      // result register can take a new result this cycle
   logic is_pair;       // current mode gives two results per request
   logic cur_last;      // result being formed is the last of its request
   logic s1_advance;    // s1 hands a result to the output register
   logic s1_done;       // s1 finishes its request this cycle
   logic req_take;

   assign is_pair    = (pixel_mode_ff == MODE_YUV16_PAIR) ||
                       (pixel_mode_ff == MODE_YUV8_PAIR);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_last   = !is_pair || phase_ff;
   assign s1_advance = s1_valid_ff && out_free;
   assign s1_done    = s1_advance && cur_last;
   assign req_stall  = s1_valid_ff && !s1_done;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      phase_in    = phase_ff;
      if (s1_advance) begin
         phase_in = !cur_last;
         if (cur_last) begin
            s1_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         phase_in    = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Datapath: while the result side does not stall, one pixel per cycle out of the input register
   // ------------------------------------------------------------------------
   logic [15:0]        s16 [4];
   logic [7:0]         b8  [4];
   logic [31:0]        lw, sw;
   logic               wide;
   logic signed [16:0] y_s, u_s, v_s;
   logic signed [32:0] r_sum, g_sum, b_sum;
   logic [CHAN_W-1:0]  grey, red_in, green_in, blue_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s16[k] = s1_word_ff[16*k +: 16];
         b8[k]  = s1_word_ff[8*k +: 8];
      end
   end

   assign lw   = s1_word_ff[31:0];
   assign sw   = {lw[7:0], lw[15:8], lw[23:16], lw[31:24]};
   assign wide = (pixel_mode_ff == MODE_YUV16_PAIR);
   assign grey = s1_grey_sel_ff ? GREY_LIGHT : GREY_DARK;

   // YUV operands: 16-bit word is Y1 V Y2 U, 8-bit word is Y1 U Y2 V
   always_comb begin
      if (wide) begin
         y_s = $signed({1'b0, (phase_ff ? s16[2] : s16[0])}) - Y_OFS16;
         v_s = $signed({1'b0, s16[1]}) - C_OFS16;
         u_s = $signed({1'b0, s16[3]}) - C_OFS16;
      end else begin
         y_s = $signed({9'b0, (phase_ff ? b8[2] : b8[0])}) - Y_OFS8;
         u_s = $signed({9'b0, b8[1]}) - C_OFS8;
         v_s = $signed({9'b0, b8[3]}) - C_OFS8;
      end
   end

   assign r_sum = 33'(y_s) * 33'(COEF_Y) + 33'(v_s) * 33'(COEF_RV);
   assign g_sum = 33'(y_s) * 33'(COEF_Y) - 33'(u_s) * 33'(COEF_GU)
                - 33'(v_s) * 33'(COEF_GV);
   assign b_sum = 33'(y_s) * 33'(COEF_Y) + 33'(u_s) * 33'(COEF_BU);

   always_comb begin
      unique case (pixel_mode_ff)
         MODE_RGBA16_BLEND: begin
            red_in   = blend(s16[1][15:8], s16[0][15:8], grey);
            green_in = blend(s16[2][15:8], s16[0][15:8], grey);
            blue_in  = blend(s16[3][15:8], s16[0][15:8], grey);
         end
         MODE_RGB48: begin
            red_in   = s16[0][15:8];
            green_in = s16[1][15:8];
            blue_in  = s16[2][15:8];
         end
         MODE_YUV16_PAIR, MODE_YUV8_PAIR: begin
            red_in   = clamp_shift(r_sum, wide);
            green_in = clamp_shift(g_sum, wide);
            blue_in  = clamp_shift(b_sum, wide);
         end
         MODE_R210: begin
            red_in   = sw[29:22];
            green_in = sw[19:12];
            blue_in  = sw[9:2];
         end
         MODE_DPX0: begin
            red_in   = sw[31:24];
            green_in = sw[21:14];
            blue_in  = sw[11:4];
         end
         MODE_AB10: begin
            red_in   = lw[29:22];
            green_in = lw[19:12];
            blue_in  = lw[9:2];
         end
         MODE_AR10: begin
            red_in   = lw[9:2];
            green_in = lw[19:12];
            blue_in  = lw[29:22];
         end
         MODE_RGB24, MODE_BGRA8: begin
            red_in   = b8[0];
            green_in = b8[1];
            blue_in  = b8[2];
         end
         default: begin
            // unassigned modes give black
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Clocked
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff <= MODE_RESET;
         s1_valid_ff   <= 1'b0;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pixel_mode_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff     <= req_pixel_word;
         s1_grey_sel_ff <= req_column[CHECKER_BIT] ^ req_row[CHECKER_BIT];
      end
      if (s1_advance) begin
         rsp_red_ff   <= red_in;
         rsp_green_ff <= green_in;
         rsp_blue_ff  <= blue_in;
         rsp_last_ff  <= cur_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_last_of_item = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // first pixel of a pair is always followed by its second
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("second pixel of pair missing");

   // second-pixel phase only exists with a pending request
   a_phase_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (s1_valid_ff && is_pair))
      else $error("pair phase without pending request");

   // a request is only taken into a full input register when it drains
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> s1_done)
      else $error("input register overwritten");

endmodule
